@@ rtl/framed_command_receiver_assert.svh @@
// assertion macros used by the checker file
`ifndef FRAMED_COMMAND_RECEIVER_ASSERT_SVH
`define FRAMED_COMMAND_RECEIVER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fcr_pkg.sv @@
// shared types, codes and defaults of the framed command receiver
package fcr_pkg;

    // default sizes
    localparam int FrameBufSize = 64;
    localparam int TagLen       = 16;

    // byte codes
    localparam logic [7:0] CH_OPEN   = 8'h3C;
    localparam logic [7:0] CH_CLOSE  = 8'h3E;
    localparam logic [7:0] CH_D0     = 8'h30;
    localparam logic [7:0] CH_D9     = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] OP_MOTION = 8'h4D;
    localparam logic [7:0] OP_RFID   = 8'h52;
    localparam logic [7:0] OP_EMERG  = 8'h45;

    // commands
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_MOTION   = 3'd1;
    localparam logic [2:0] EV_TAG      = 3'd2;
    localparam logic [2:0] EV_EMERG    = 3'd3;
    localparam logic [2:0] EV_TAGEMPTY = 3'd4;
    localparam logic [2:0] EV_UNKNOWN  = 3'd5;
    localparam logic [2:0] EV_EMPTY    = 3'd6;
    localparam logic [2:0] EV_OVERFLOW = 3'd7;

    // input transaction
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic [3:0] tag_index;
    } t_in;

    // output transaction
    typedef struct packed {
        logic [2:0] event_res;
        logic       motion_flag;
        logic       rfid_flag;
        logic       emergency_flag;
        logic [4:0] tag_length;
        logic [7:0] tag_byte;
        logic       in_frame;
    } t_out;

    // byte classification
    typedef struct packed {
        logic keep;
        logic is_open;
        logic is_close;
    } t_class;

endpackage

@@ rtl/framed_command_receiver.sv @@
// top level of the framed command receiver
//
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+-------------------
//  input   | i_in_valid  | o_in_ready   | i_in_data  (t_in)
//  output  | o_out_valid | i_out_ready  | o_out_data (t_out)
//
// byte, clear and unused commands are answered in idle, tag reads pass a read state
// an rfid frame close copies up to TAG_LEN tag bytes one per cycle through
// the frame buffer ram read port
// synchronous active-low reset clears flags, frame state and tag length; no clearing pass
// an output register holds a finished result, so one more transaction runs under a stall
module framed_command_receiver #(
    parameter int FRAME_BUF_SIZE = fcr_pkg::FrameBufSize,
    parameter int TAG_LEN        = fcr_pkg::TagLen
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fcr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fcr_pkg::t_out o_out_data
);
    import fcr_pkg::*;

    localparam int FDEPTH = FRAME_BUF_SIZE - 1;
    localparam int FAW    = $clog2(FDEPTH);
    localparam int TAW    = (TAG_LEN > 1) ? $clog2(TAG_LEN) : 1;

    t_class         w_class;
    logic           w_fr_we;
    logic [FAW-1:0] w_fr_waddr;
    logic [7:0]     w_fr_wdata;
    logic [FAW-1:0] w_fr_raddr;
    logic [7:0]     w_fr_rdata;
    logic           w_tag_we;
    logic [TAW-1:0] w_tag_waddr;
    logic [7:0]     w_tag_wdata;
    logic [TAW-1:0] w_tag_raddr;
    logic [7:0]     w_tag_rdata;
    logic           w_res_valid;
    logic           w_res_ready;
    t_out           w_res;
    logic           r_out_v, n_out_v;
    t_out           r_out;

    // byte filter
    fcr_class u_class (
        .i_byte  (i_in_data.rx_byte),
        .o_class (w_class)
    );

    // frame buffer
    fcr_ram #(
        .WIDTH (8),
        .DEPTH (FDEPTH),
        .AW    (FAW)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_fr_we),
        .i_waddr (w_fr_waddr),
        .i_wdata (w_fr_wdata),
        .i_raddr (w_fr_raddr),
        .o_rdata (w_fr_rdata)
    );

    // tag store
    fcr_ram #(
        .WIDTH (8),
        .DEPTH (TAG_LEN),
        .AW    (TAW)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (w_tag_waddr),
        .i_wdata (w_tag_wdata),
        .i_raddr (w_tag_raddr),
        .o_rdata (w_tag_rdata)
    );

    // sequencer
    fcr_ctrl #(
        .FRAME_BUF_SIZE (FRAME_BUF_SIZE),
        .TAG_LEN        (TAG_LEN),
        .FAW            (FAW),
        .TAW            (TAW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_class     (w_class),
        .o_fr_we     (w_fr_we),
        .o_fr_waddr  (w_fr_waddr),
        .o_fr_wdata  (w_fr_wdata),
        .o_fr_raddr  (w_fr_raddr),
        .i_fr_rdata  (w_fr_rdata),
        .o_tag_we    (w_tag_we),
        .o_tag_waddr (w_tag_waddr),
        .o_tag_wdata (w_tag_wdata),
        .o_tag_raddr (w_tag_raddr),
        .i_tag_rdata (w_tag_rdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // output register
    assign w_res_ready = !r_out_v || i_out_ready;

    always_comb begin
        n_out_v = r_out_v;
        if (w_res_valid && w_res_ready) begin
            n_out_v = 1'b1;
        end else if (i_out_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= n_out_v;
        end
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

@@ rtl/fcr_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module fcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fcr_class.sv @@
// received byte filter: kept characters and delimiters
module fcr_class (
    input  logic [7:0]     i_byte,
    output fcr_pkg::t_class o_class
);
    import fcr_pkg::*;

    logic w_digit;
    logic w_upper;

    // digits and upper-case letters
    assign w_digit = (i_byte >= CH_D0) && (i_byte <= CH_D9);
    assign w_upper = (i_byte >= CH_UA) && (i_byte <= CH_UZ);

    // delimiters
    assign o_class.is_open  = (i_byte == CH_OPEN);
    assign o_class.is_close = (i_byte == CH_CLOSE);
    assign o_class.keep     = w_digit || w_upper || o_class.is_open || o_class.is_close;

endmodule

@@ rtl/fcr_ctrl.sv @@
// frame sequencer: frame state, flags, buffer writes and tag copy
module fcr_ctrl #(
    parameter int FRAME_BUF_SIZE = fcr_pkg::FrameBufSize,
    parameter int TAG_LEN        = fcr_pkg::TagLen,
    parameter int FAW            = $clog2(FRAME_BUF_SIZE - 1),
    parameter int TAW            = (TAG_LEN > 1) ? $clog2(TAG_LEN) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fcr_pkg::t_in    i_in_data,
    input  fcr_pkg::t_class i_class,
    output logic            o_fr_we,
    output logic [FAW-1:0]  o_fr_waddr,
    output logic [7:0]      o_fr_wdata,
    output logic [FAW-1:0]  o_fr_raddr,
    input  logic [7:0]      i_fr_rdata,
    output logic            o_tag_we,
    output logic [TAW-1:0]  o_tag_waddr,
    output logic [7:0]      o_tag_wdata,
    output logic [TAW-1:0]  o_tag_raddr,
    input  logic [7:0]      i_tag_rdata,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output fcr_pkg::t_out   o_res
);
    import fcr_pkg::*;

    localparam int FDEPTH = FRAME_BUF_SIZE - 1;
    localparam int FCW    = $clog2(FRAME_BUF_SIZE);
    localparam int TCW    = $clog2(TAG_LEN + 1);
    localparam int MW     = (FCW > TCW) ? FCW : TCW;
    localparam int IW     = (TCW > 4) ? TCW : 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_DRAIN
    } t_state;

    t_state         r_state,     n_state;
    logic           r_open,      n_open;
    logic [FCW-1:0] r_count,     n_count;
    logic [7:0]     r_op,        n_op;
    logic           r_motion,    n_motion;
    logic           r_rfid,      n_rfid;
    logic           r_emerg,     n_emerg;
    logic [TCW-1:0] r_tag_count, n_tag_count;
    logic [TCW-1:0] r_k,         n_k;
    logic [TCW-1:0] r_n,         n_n;
    logic           r_wv,        n_wv;
    logic [TAW-1:0] r_wa,        n_wa;
    logic           r_rd_ok,     n_rd_ok;
    logic           r_pend_v,    n_pend_v;
    t_out           r_pend,      n_pend;

    logic           w_accept;
    logic           w_room;
    logic [IW-1:0]  w_idx;
    logic [MW-1:0]  w_rd_wide;
    logic [MW-1:0]  w_data_len;
    logic           v_emit;
    logic [2:0]     v_ev;
    logic [7:0]     v_tb;

    assign o_in_ready = (r_state == ST_IDLE) && !r_pend_v;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_room     = (r_count < FCW'(FDEPTH));

    // frame buffer write port: data bytes of an open frame
    assign o_fr_we    = w_accept && (i_in_data.command == CMD_BYTE) && i_class.keep &&
                        !i_class.is_open && !i_class.is_close && r_open && w_room;
    assign o_fr_waddr = r_count[FAW-1:0];
    assign o_fr_wdata = i_in_data.rx_byte;

    // frame buffer read port: tag data starts after the opcode
    assign w_rd_wide  = MW'(r_k) + MW'(1);
    assign o_fr_raddr = w_rd_wide[FAW-1:0];

    // tag store ports
    assign w_idx       = IW'(i_in_data.tag_index);
    assign o_tag_raddr = w_idx[TAW-1:0];
    assign o_tag_we    = r_wv;
    assign o_tag_waddr = r_wa;
    assign o_tag_wdata = i_fr_rdata;

    // data bytes after the opcode, cut to the tag size when the copy starts
    assign w_data_len = MW'(r_count) - MW'(1);

    assign o_res_valid = r_pend_v;
    assign o_res       = r_pend;

    // next state
    always_comb begin
        n_state     = r_state;
        n_open      = r_open;
        n_count     = r_count;
        n_op        = r_op;
        n_motion    = r_motion;
        n_rfid      = r_rfid;
        n_emerg     = r_emerg;
        n_tag_count = r_tag_count;
        n_k         = r_k;
        n_n         = r_n;
        n_wv        = (r_state == ST_COPY);
        n_wa        = r_k[TAW-1:0];
        n_rd_ok     = r_rd_ok;
        n_pend_v    = r_pend_v && !i_res_ready;
        n_pend      = r_pend;
        v_emit      = 1'b0;
        v_ev        = EV_NONE;
        v_tb        = 8'd0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.command)
                        CMD_BYTE: begin
                            v_emit = 1'b1;
                            if (!i_class.keep) begin
                                v_ev = EV_NONE;
                            end else if (i_class.is_open) begin
                                n_open  = 1'b1;
                                n_count = '0;
                            end else if (!r_open) begin
                                v_ev = EV_NONE;
                            end else if (i_class.is_close) begin
                                n_open  = 1'b0;
                                n_count = '0;
                                if (r_count == '0) begin
                                    v_ev = EV_EMPTY;
                                end else if (r_op == OP_MOTION) begin
                                    n_motion = 1'b1;
                                    v_ev     = EV_MOTION;
                                end else if (r_op == OP_EMERG) begin
                                    n_emerg = 1'b1;
                                    v_ev    = EV_EMERG;
                                end else if (r_op == OP_RFID) begin
                                    if (r_count == FCW'(1)) begin
                                        v_ev = EV_TAGEMPTY;
                                    end else begin
                                        // tag copy runs before the result
                                        v_emit  = 1'b0;
                                        n_k     = '0;
                                        n_n     = (w_data_len > MW'(TAG_LEN)) ?
                                                  TCW'(TAG_LEN) : TCW'(w_data_len);
                                        n_state = ST_COPY;
                                    end
                                end else begin
                                    v_ev = EV_UNKNOWN;
                                end
                            end else if (w_room) begin
                                n_count = r_count + FCW'(1);
                                if (r_count == '0) begin
                                    n_op = i_in_data.rx_byte;
                                end
                            end else begin
                                n_open  = 1'b0;
                                n_count = '0;
                                v_ev    = EV_OVERFLOW;
                            end
                        end
                        CMD_CLEAR: begin
                            n_motion    = 1'b0;
                            n_rfid      = 1'b0;
                            n_emerg     = 1'b0;
                            n_tag_count = '0;
                            v_emit      = 1'b1;
                        end
                        CMD_READ: begin
                            n_rd_ok = (w_idx < IW'(r_tag_count)) && (w_idx < IW'(TAG_LEN));
                            n_state = ST_READ;
                        end
                        default: begin
                            v_emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                v_emit  = 1'b1;
                v_tb    = r_rd_ok ? i_tag_rdata : 8'd0;
                n_state = ST_IDLE;
            end
            ST_COPY: begin
                // one tag byte read per cycle, written to the tag store in the cycle after
                n_k = r_k + TCW'(1);
                if (r_k == r_n - TCW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_tag_count = r_n;
                n_rfid      = 1'b1;
                v_ev        = EV_TAG;
                v_emit      = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // result with the state after the transaction
        if (v_emit) begin
            n_pend_v              = 1'b1;
            n_pend.event_res      = v_ev;
            n_pend.motion_flag    = n_motion;
            n_pend.rfid_flag      = n_rfid;
            n_pend.emergency_flag = n_emerg;
            n_pend.tag_length     = 5'(n_tag_count);
            n_pend.tag_byte       = v_tb;
            n_pend.in_frame       = n_open;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_open      <= 1'b0;
            r_count     <= '0;
            r_motion    <= 1'b0;
            r_rfid      <= 1'b0;
            r_emerg     <= 1'b0;
            r_tag_count <= '0;
            r_wv        <= 1'b0;
            r_pend_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_count     <= n_count;
            r_motion    <= n_motion;
            r_rfid      <= n_rfid;
            r_emerg     <= n_emerg;
            r_tag_count <= n_tag_count;
            r_wv        <= n_wv;
            r_pend_v    <= n_pend_v;
        end
        r_op    <= n_op;
        r_k     <= n_k;
        r_n     <= n_n;
        r_wa    <= n_wa;
        r_rd_ok <= n_rd_ok;
        r_pend  <= n_pend;
    end

endmodule

@@ rtl/fcr_checker.sv @@
// port-level checks of the framed command receiver and their binding
`include "framed_command_receiver_assert.svh"

module fcr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input fcr_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input fcr_pkg::t_out o_out_data
);
    import fcr_pkg::*;

    // a stalled result transaction holds
    `FCR_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result changed while stalled")

    // a waiting input transaction holds
    `FCR_ASSERT_NXT(a_in_hold, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_data), "input changed while waiting")

    // overflow always closes the frame
    `FCR_ASSERT_IMP(a_ovf_closed, o_out_valid && o_out_data.event_res == EV_OVERFLOW, !o_out_data.in_frame, "frame open after overflow")

    // a stored tag sets the rfid flag
    `FCR_ASSERT_IMP(a_tag_flag, o_out_valid && o_out_data.event_res == EV_TAG, o_out_data.rfid_flag, "rfid flag low after tag")

    // tag bytes only come back on reads, which raise no event
    `FCR_ASSERT_IMP(a_tb_no_event, o_out_valid && o_out_data.tag_byte != 8'd0, o_out_data.event_res == EV_NONE, "tag byte with an event")

endmodule

bind framed_command_receiver fcr_checker u_fcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
